[rtl/csx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR package
// Shared constants and types for the ChaCha20 stream XOR block.
// ----------------------------------------------------------------------------
package csx_pkg;
  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned RoundCount   = 2 * DoubleRounds;
  localparam int unsigned RoundW       = $clog2(RoundCount + 1);
  localparam int unsigned QueueDepth   = 2;

  localparam logic [2:0] CfgKey01   = 3'd0;
  localparam logic [2:0] CfgKey23   = 3'd1;
  localparam logic [2:0] CfgKey45   = 3'd2;
  localparam logic [2:0] CfgKey67   = 3'd3;
  localparam logic [2:0] CfgNonce01 = 3'd4;
  localparam logic [2:0] CfgNonce2  = 3'd5;
  localparam logic [2:0] CfgStart   = 3'd6;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef logic [15:0][31:0] state_t;

  // One classified word travelling from the front to the back.
  typedef struct packed {
    logic [31:0] msg;
    logic        last;
    logic        new_block;
    logic [3:0]  index;
    logic [31:0] counter;
  } item_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b;   td = rotl(d ^ ta, 16);
    tc = c + td;  tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    quarter = {ta, tb, tc, td};
  endfunction
endpackage

[rtl/chacha20_stream_xor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR top level
// Word-by-word ChaCha20 (96-bit nonce) encryption and decryption.
// ----------------------------------------------------------------------------
// Usage:
//   Write key, nonce and start counter on the cfg channel while idle.
//   Each input beat carries one 32-bit message word, a restart flag and a
//   final flag; each output beat carries the XORed word and the final flag.
//   The front end tracks word position and counter and pushes tagged words
//   into a two-entry queue; the back end owns the shared round unit.
//   A word that opens a 64-byte block waits for the block function:
//   20 rounds, one per cycle, then the final add of the input state. Other
//   words leave through the output register, one per cycle while the
//   receiver is ready and no block is being built.
//   Reset clears the position, the counter, the cfg registers and the queue.
//   When the receiver stalls, the output register holds its beat, the queue
//   fills, and in_ready_o drops.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_top import csx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] message_word_i,
  input  logic        restart_i,
  input  logic        final_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] cipher_word_o,
  output logic        last_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  logic [255:0] key_q;
  logic [95:0]  nonce_q;
  logic [31:0]  start_q;
  logic         q_valid, q_ready;
  item_t        q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
      start_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKey01:   key_q[63:0]    <= cfg_data_i;
        CfgKey23:   key_q[127:64]  <= cfg_data_i;
        CfgKey45:   key_q[191:128] <= cfg_data_i;
        CfgKey67:   key_q[255:192] <= cfg_data_i;
        CfgNonce01: nonce_q[63:0]  <= cfg_data_i;
        CfgNonce2:  nonce_q[95:64] <= cfg_data_i[31:0];
        CfgStart:   start_q        <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  csx_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .message_word_i, .restart_i, .final_word_i,
    .start_counter_i(start_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  csx_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .key_i(key_q), .nonce_i(nonce_q),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .cipher_word_o, .last_out_o
  );
endmodule

[rtl/csx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR front end
// Tracks word position and block counter, tags each word, feeds the queue.
// ----------------------------------------------------------------------------
module csx_front import csx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] message_word_i,
  input  logic        restart_i,
  input  logic        final_word_i,
  input  logic [31:0] start_counter_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic [3:0]  index_q, index_d;
  logic [31:0] counter_q, counter_d;
  item_t       queue_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic push, pop;
  logic [3:0]  cur_index;
  logic [31:0] cur_counter;

  assign ready_o   = (cnt_q != (PtrW+1)'(QueueDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = queue_q[rd_q];
  assign push = valid_i && ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    cur_index   = restart_i ? 4'd0 : index_q;
    cur_counter = restart_i ? start_counter_i : counter_q;
    index_d     = cur_index + 4'd1;
    counter_d   = (cur_index == 4'd15) ? cur_counter + 32'd1 : cur_counter;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q   <= '0;
      counter_q <= '0;
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
    end else begin
      if (push) begin
        index_q   <= index_d;
        counter_q <= counter_d;
        wr_q      <= wr_q + PtrW'(1);
      end
      if (pop) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_q] <= '{msg: message_word_i, last: final_word_i,
                         new_block: (cur_index == 4'd0), index: cur_index,
                         counter: cur_counter};
    end
  end
endmodule

[rtl/csx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR back end
// Runs the block function one round a cycle and XORs words with keystream.
// ----------------------------------------------------------------------------
module csx_back import csx_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  output logic         q_ready_o,
  input  item_t        q_item_i,
  input  logic [255:0] key_i,
  input  logic [95:0]  nonce_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [31:0]  cipher_word_o,
  output logic         last_out_o
);
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StAdd   = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [RoundW-1:0] round_q;
  state_t            init_q, work_q, ks_q, init_w, round_w;
  logic              out_valid_q;
  logic [31:0]       out_word_q;
  logic              out_last_q;
  logic              out_free;
  logic              blk_done_q;
  logic              take_any;

  assign out_free = !out_valid_q || ready_i;
  assign take_any = q_valid_i && out_free && (state_q == StIdle)
                    && (!q_item_i.new_block || blk_done_q);
  assign q_ready_o = take_any;
  assign valid_o = out_valid_q;
  assign cipher_word_o = out_word_q;
  assign last_out_o = out_last_q;

  always_comb begin
    init_w = {nonce_i[95:64], nonce_i[63:32], nonce_i[31:0], q_item_i.counter,
              key_i[255:224], key_i[223:192], key_i[191:160], key_i[159:128],
              key_i[127:96], key_i[95:64], key_i[63:32], key_i[31:0],
              Sigma3, Sigma2, Sigma1, Sigma0};
  end

  // Even rounds work on columns, odd rounds on diagonals.
  always_comb begin
    logic [127:0] r0, r1, r2, r3;
    round_w = work_q;
    if (!round_q[0]) begin
      r0 = quarter(work_q[0], work_q[4], work_q[8],  work_q[12]);
      r1 = quarter(work_q[1], work_q[5], work_q[9],  work_q[13]);
      r2 = quarter(work_q[2], work_q[6], work_q[10], work_q[14]);
      r3 = quarter(work_q[3], work_q[7], work_q[11], work_q[15]);
      {round_w[0], round_w[4], round_w[8],  round_w[12]} = r0;
      {round_w[1], round_w[5], round_w[9],  round_w[13]} = r1;
      {round_w[2], round_w[6], round_w[10], round_w[14]} = r2;
      {round_w[3], round_w[7], round_w[11], round_w[15]} = r3;
    end else begin
      r0 = quarter(work_q[0], work_q[5], work_q[10], work_q[15]);
      r1 = quarter(work_q[1], work_q[6], work_q[11], work_q[12]);
      r2 = quarter(work_q[2], work_q[7], work_q[8],  work_q[13]);
      r3 = quarter(work_q[3], work_q[4], work_q[9],  work_q[14]);
      {round_w[0], round_w[5], round_w[10], round_w[15]} = r0;
      {round_w[1], round_w[6], round_w[11], round_w[12]} = r1;
      {round_w[2], round_w[7], round_w[8],  round_w[13]} = r2;
      {round_w[3], round_w[4], round_w[9],  round_w[14]} = r3;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (q_valid_i && q_item_i.new_block && !blk_done_q) state_d = StRound;
      StRound: if (round_q == RoundW'(RoundCount - 1)) state_d = StAdd;
      StAdd:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) round_q <= '0;
      else if (state_q == StRound) round_q <= round_q + RoundW'(1);
      if (take_any) out_valid_q <= 1'b1;
      else if (ready_i) out_valid_q <= 1'b0;
    end
  end

  // Set once the keystream for the word at the queue head has been built, so
  // that word can leave without starting another block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) blk_done_q <= 1'b0;
    else if (state_q == StAdd) blk_done_q <= 1'b1;
    else if (q_valid_i && q_ready_o) blk_done_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i && q_item_i.new_block && !blk_done_q) begin
      init_q <= init_w;
      work_q <= init_w;
    end else if (state_q == StRound) begin
      work_q <= round_w;
    end
    if (state_q == StAdd) begin
      for (int i = 0; i < 16; i++) ks_q[i] <= work_q[i] + init_q[i];
    end
    if (take_any) begin
      out_word_q <= q_item_i.msg ^ ks_q[q_item_i.index];
      out_last_q <= q_item_i.last;
    end
  end
endmodule
